/* hw/rtl/gfas_pkg.sv */
// ----------------------------------------------------------------------------
// gfas_pkg
// Shared types, constants and helpers for the three-axis gyro block
// averager with full-scale conversion.
// ----------------------------------------------------------------------------
package gfas_pkg;

  // default run capacity in slots
  localparam int DEF_MAX_SLOTS = 32;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int OPND_W    = 17;   // signed quotient or sample, holds +32768
  localparam int FACTOR_W  = 17;   // largest factor is 70000
  localparam int RATE_W    = 33;
  localparam int COUNT_W   = 6;
  localparam int SCALE_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGING_MODE = 1'd1;

  // full-scale select codes
  localparam logic [SCALE_W-1:0] SCALE_245DPS  = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_500DPS  = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_2000DPS = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_NONE    = 2'd3;

  // averaging mode codes
  localparam logic MODE_BYPASS = 1'b0;
  localparam logic MODE_STREAM = 1'b1;

  // sensitivity in micro-degrees per second per LSB
  localparam logic [FACTOR_W-1:0] FACTOR_245DPS  = 17'd8750;
  localparam logic [FACTOR_W-1:0] FACTOR_500DPS  = 17'd17500;
  localparam logic [FACTOR_W-1:0] FACTOR_2000DPS = 17'd70000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } gfas_state_t;

  // per-cycle commands from the sequencer to every lane
  typedef struct packed {
    logic acc;        // add negated sample into the running sum
    logic run_end;    // latch the new sum as dividend, clear the sum
    logic load_raw;   // take the sample as multiplier operand
    logic step;       // one restoring division step
    logic finish;     // last step: write the signed quotient as operand
  } gfas_lane_ctrl_t;

  function automatic logic [FACTOR_W-1:0] scale_factor(input logic [SCALE_W-1:0] sel);
    logic [FACTOR_W-1:0] f;
    case (sel)
      SCALE_245DPS:  f = FACTOR_245DPS;
      SCALE_500DPS:  f = FACTOR_500DPS;
      SCALE_2000DPS: f = FACTOR_2000DPS;
      SCALE_NONE:    f = '0;
      default:       f = '0;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/gfas_lane.sv */
// ----------------------------------------------------------------------------
// gfas_lane
// One axis: running sum of negated samples, bit-serial restoring divider
// for the run average, and the full-scale multiply.
// ----------------------------------------------------------------------------
module gfas_lane #(
  parameter int MAX_SLOTS = gfas_pkg::DEF_MAX_SLOTS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  gfas_pkg::gfas_lane_ctrl_t               ctrl,
  input  logic signed [gfas_pkg::SAMPLE_W-1:0]    sample,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]          den,
  input  logic [gfas_pkg::FACTOR_W-1:0]           factor,
  output logic signed [gfas_pkg::RATE_W-1:0]      rate
);
  import gfas_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SLOTS);
  localparam int PROD_W = OPND_W + FACTOR_W + 1;

  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SAMPLE_W-1:0] sample_neg;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           quo;
  logic [SUM_W-1:0]           quo_next;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W:0]             rem_shift;
  logic [CNT_W:0]             rem_sub;
  logic                       ge;
  logic                       neg;
  logic [OPND_W-1:0]          quo_mag;
  logic signed [OPND_W-1:0]   opnd;
  logic signed [PROD_W-1:0]   prod;

  // 16-bit wrap negate: the most negative sample maps onto itself
  assign sample_neg = -sample;
  assign sum_next   = sum + SUM_W'(sample_neg);
  assign sum_mag    = sum_next[SUM_W-1] ? -sum_next : sum_next;

  // restoring division step, one quotient bit per cycle
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign ge        = (rem_shift >= {1'b0, den});
  assign rem_sub   = rem_shift - {1'b0, den};
  assign quo_next  = {quo[SUM_W-2:0], ge};
  assign quo_mag   = OPND_W'({1'b0, quo_next});

  // running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.run_end) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= sum_next;
    end
  end

  // divider and operand
  always_ff @(posedge clk) begin
    if (ctrl.run_end) begin
      quo <= sum_mag;
      rem <= '0;
      neg <= sum_next[SUM_W-1];
    end else if (ctrl.step) begin
      quo <= quo_next;
      rem <= ge ? CNT_W'(rem_sub) : CNT_W'(rem_shift);
    end
    if (ctrl.load_raw) begin
      opnd <= OPND_W'(sample);
    end else if (ctrl.finish) begin
      opnd <= neg ? -$signed(quo_mag) : $signed(quo_mag);
    end
  end

  // full-scale multiply, registered by the merge stage
  assign prod = opnd * $signed({1'b0, factor});
  assign rate = prod[RATE_W-1:0];

endmodule

/* hw/rtl/gyro_fifo_average_scale.sv */
// ----------------------------------------------------------------------------
// gyro_fifo_average_scale
// Three-axis gyro FIFO averager with full-scale conversion to micro-degrees
// per second. Three axis lanes work side by side; this level sequences them
// and merges their results into one output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one FIFO slot (X/Y/Z little-endian byte pairs and a
//   last mark) on in_valid / in_stall. Results leave on out_valid /
//   out_stall and sit in an output register until taken.
//   Bypass mode: each slot gives one result, registered as multiply operand
//   and then in the output register; no new slot is taken until it is there.
//   Stream mode: slots that do not end a run are taken one per cycle and
//   give no result. A slot that ends a run (last mark, or the MAX_SLOTS-th
//   slot) starts a bit-serial divide over the SUM_W = 16 + clog2(MAX_SLOTS)
//   bit sum (21 at 32 slots), run in step by the three lanes, then the
//   multiply state, and in_stall is high meanwhile.
//   If the receiver stalls, the finished result waits in the multiply stage
//   until the output register frees; new slots are still taken while a
//   result waits in the output register.
//   Reset clears the sums and slot count, sets scale_select to the invalid
//   code (rates read zero) and selects bypass mode.
// ----------------------------------------------------------------------------
module gyro_fifo_average_scale #(
  parameter int MAX_SLOTS = gfas_pkg::DEF_MAX_SLOTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic [gfas_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gfas_pkg::CFG_DAT_W-1:0]         cfg_data,
  // input slot
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [gfas_pkg::BYTE_W-1:0]            x_low,
  input  logic [gfas_pkg::BYTE_W-1:0]            x_high,
  input  logic [gfas_pkg::BYTE_W-1:0]            y_low,
  input  logic [gfas_pkg::BYTE_W-1:0]            y_high,
  input  logic [gfas_pkg::BYTE_W-1:0]            z_low,
  input  logic [gfas_pkg::BYTE_W-1:0]            z_high,
  input  logic                                   last_slot,
  // result
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [gfas_pkg::RATE_W-1:0]     rate_x,
  output logic signed [gfas_pkg::RATE_W-1:0]     rate_y,
  output logic signed [gfas_pkg::RATE_W-1:0]     rate_z,
  output logic [gfas_pkg::COUNT_W-1:0]           slots_averaged,
  output logic                                   forced_end
);
  import gfas_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SLOTS);
  localparam int STEP_W = $clog2(SUM_W);

  gfas_state_t                state;
  gfas_state_t                state_next;
  gfas_lane_ctrl_t            ctrl;
  logic [SCALE_W-1:0]         scale_select;
  logic                       averaging_mode;
  logic [CNT_W-1:0]           slot_count;
  logic [CNT_W-1:0]           count_inc;
  logic [CNT_W-1:0]           den;
  logic [CNT_W-1:0]           res_count;
  logic                       res_forced;
  logic [STEP_W-1:0]          step_cnt;
  logic                       in_fire;
  logic                       run_done;
  logic                       forced;
  logic                       out_free;
  logic [FACTOR_W-1:0]        factor;
  logic signed [RATE_W-1:0]   lane_x;
  logic signed [RATE_W-1:0]   lane_y;
  logic signed [RATE_W-1:0]   lane_z;

  assign in_fire   = in_valid && !in_stall;
  assign count_inc = slot_count + CNT_W'(1);
  assign forced    = !last_slot && (count_inc >= CNT_W'(MAX_SLOTS));
  assign run_done  = last_slot || forced;
  assign out_free  = !out_valid || !out_stall;
  assign factor    = scale_factor(scale_select);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_select   <= SCALE_NONE;
      averaging_mode <= MODE_BYPASS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_SELECT:   scale_select   <= cfg_data;
        REG_AVERAGING_MODE: averaging_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (averaging_mode == MODE_BYPASS) begin
            state_next = ST_MUL;
          end else if (run_done) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (step_cnt == '0) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // lane commands and input stall
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (averaging_mode == MODE_BYPASS) begin
            ctrl.load_raw = 1'b1;
          end else begin
            ctrl.acc     = 1'b1;
            ctrl.run_end = run_done;
          end
        end
      end
      ST_DIV: begin
        ctrl.step   = 1'b1;
        ctrl.finish = (step_cnt == '0);
      end
      ST_MUL: ;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_count <= '0;
    end else begin
      state <= state_next;
      if (in_fire && averaging_mode == MODE_STREAM) begin
        slot_count <= run_done ? '0 : count_inc;
      end
    end
  end

  // per-run bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (averaging_mode == MODE_BYPASS) begin
        res_count  <= CNT_W'(1);
        res_forced <= 1'b0;
      end else if (run_done) begin
        den        <= count_inc;
        res_count  <= count_inc;
        res_forced <= forced;
        step_cnt   <= STEP_W'(SUM_W - 1);
      end
    end else if (state == ST_DIV) begin
      step_cnt <= step_cnt - STEP_W'(1);
    end
  end

  // axis lanes
  gfas_lane #(.MAX_SLOTS(MAX_SLOTS)) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample ($signed({x_high, x_low})),
    .den    (den),
    .factor (factor),
    .rate   (lane_x)
  );

  gfas_lane #(.MAX_SLOTS(MAX_SLOTS)) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample ($signed({y_high, y_low})),
    .den    (den),
    .factor (factor),
    .rate   (lane_y)
  );

  gfas_lane #(.MAX_SLOTS(MAX_SLOTS)) u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample ($signed({z_high, z_low})),
    .den    (den),
    .factor (factor),
    .rate   (lane_z)
  );

  // merge stage: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_MUL && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL && out_free) begin
      rate_x         <= lane_x;
      rate_y         <= lane_y;
      rate_z         <= lane_z;
      slots_averaged <= COUNT_W'(res_count);
      forced_end     <= res_forced;
    end
  end

endmodule

/* tb/gyro_fifo_average_scale_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_fifo_average_scale_test
// Self-checking bench for the three-axis gyro FIFO averager. A directed
// table covers reset state, sample extremes, every full-scale setting,
// wrap on negation, truncation, mode changes mid-run and the forced end of
// a full run. Random bursts follow under changing register settings and
// handshake pressure. Each result is checked against an in-bench model or a typed table value.
// ----------------------------------------------------------------------------
module gyro_fifo_average_scale_test;
  import gfas_pkg::*;

  localparam int RUN_SLOTS    = 32;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_SLOTS = 1700;
  localparam int PRINT_CAP    = 100;

  // sensitivity in micro-degrees per second per LSB
  localparam longint UDPS_245  = 8750;
  localparam longint UDPS_500  = 17500;
  localparam longint UDPS_2000 = 70000;

  typedef struct {
    logic [BYTE_W-1:0] xl, xh, yl, yh, zl, zh;
    logic              last;
  } gyro_slot_t;

  typedef struct {
    logic signed [RATE_W-1:0] rx, ry, rz;
    logic [COUNT_W-1:0]       cnt;
    logic                     forced;
  } rate_result_t;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    logic               mode;
    int                 reps;
    gyro_slot_t         slot;
    bit                 typed;
    rate_result_t       want;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [BYTE_W-1:0]        x_low, x_high, y_low, y_high, z_low, z_high;
  logic                     last_slot;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
  logic [COUNT_W-1:0]       slots_averaged;
  logic                     forced_end;

  // model copy of registers and run state
  logic [SCALE_W-1:0] model_scale;
  logic               model_mode;
  int                 sum_x, sum_y, sum_z, run_len;

  rate_result_t rates_due[$];
  plan_row_t    directed_plan[$];
  rate_result_t no_rate;
  int           idle_mode = 0;
  int           mismatches = 0;
  int           cycles = 0;
  int           accepted = 0;

  gyro_fifo_average_scale dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .x_low          (x_low),
    .x_high         (x_high),
    .y_low          (y_low),
    .y_high         (y_high),
    .z_low          (z_low),
    .z_high         (z_high),
    .last_slot      (last_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rate_x         (rate_x),
    .rate_y         (rate_y),
    .rate_z         (rate_z),
    .slots_averaged (slots_averaged),
    .forced_end     (forced_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("gyro_fifo_average_scale_test: errors");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    case (idle_mode)
      0:       out_stall <= ($urandom_range(99) < 75);
      1:       out_stall <= ($urandom_range(99) < 29);
      default: out_stall <= 1'b0;
    endcase
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int sample_of(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
    logic signed [SAMPLE_W-1:0] w;
    w = {hi, lo};
    return int'(w);
  endfunction

  // 16-bit wrap: the most negative sample maps onto itself
  function automatic int wrap_negate(input int v);
    return (v == -32768) ? v : -v;
  endfunction

  function automatic rate_result_t scaled(input int ax, input int ay, input int az,
                                          input int cnt, input bit forced);
    rate_result_t r;
    longint f;
    case (model_scale)
      SCALE_245DPS:  f = UDPS_245;
      SCALE_500DPS:  f = UDPS_500;
      SCALE_2000DPS: f = UDPS_2000;
      default:       f = 0;
    endcase
    r.rx     = RATE_W'(ax * f);
    r.ry     = RATE_W'(ay * f);
    r.rz     = RATE_W'(az * f);
    r.cnt    = COUNT_W'(cnt);
    r.forced = forced;
    return r;
  endfunction

  // model of one accepted slot: updates the run and tells if a result is due
  task automatic predict_rate(input gyro_slot_t s, output bit produced, output rate_result_t r);
    int sx, sy, sz;
    bit forced;
    sx = sample_of(s.xl, s.xh);
    sy = sample_of(s.yl, s.yh);
    sz = sample_of(s.zl, s.zh);
    if (model_mode == MODE_BYPASS) begin
      produced = 1'b1;
      r = scaled(sx, sy, sz, 1, 1'b0);
    end else begin
      sum_x += wrap_negate(sx);
      sum_y += wrap_negate(sy);
      sum_z += wrap_negate(sz);
      run_len++;
      forced = !s.last && run_len >= RUN_SLOTS;
      produced = s.last || forced;
      if (produced) begin
        // int division truncates toward zero
        r = scaled(sum_x / run_len, sum_y / run_len, sum_z / run_len, run_len, forced);
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        run_len = 0;
      end
    end
  endtask

  function automatic void add_row(input logic [SCALE_W-1:0] scale, input logic mode,
                                  input int reps, input logic [15:0] x, input logic [15:0] y,
                                  input logic [15:0] z, input logic last, input bit typed = 0,
                                  input longint rx = 0, input longint ry = 0,
                                  input longint rz = 0, input int cnt = 0,
                                  input bit forced = 0);
    plan_row_t r;
    r.scale       = scale;
    r.mode        = mode;
    r.reps        = reps;
    r.slot.xl     = x[7:0];
    r.slot.xh     = x[15:8];
    r.slot.yl     = y[7:0];
    r.slot.yh     = y[15:8];
    r.slot.zl     = z[7:0];
    r.slot.zh     = z[15:8];
    r.slot.last   = last;
    r.typed       = typed;
    r.want.rx     = rx[RATE_W-1:0];
    r.want.ry     = ry[RATE_W-1:0];
    r.want.rz     = rz[RATE_W-1:0];
    r.want.cnt    = COUNT_W'(cnt);
    r.want.forced = forced;
    directed_plan.push_back(r);
  endfunction

  // bytes lean toward the sign and range edges
  function automatic logic [BYTE_W-1:0] rand_byte();
    logic [BYTE_W-1:0] edges[4];
    edges = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(4) == 0)
      return edges[2'($urandom_range(3))];
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic gyro_slot_t random_slot();
    gyro_slot_t s;
    s.xl   = rand_byte();
    s.xh   = rand_byte();
    s.yl   = rand_byte();
    s.yh   = rand_byte();
    s.zl   = rand_byte();
    s.zh   = rand_byte();
    s.last = 1'($urandom_range(1));
    return s;
  endfunction

  // one input request, with random idle cycles ahead of it
  task automatic send_slot(input gyro_slot_t s, input bit typed, input rate_result_t want);
    bit produced;
    rate_result_t r;
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 75 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    x_low     <= s.xl;
    x_high    <= s.xh;
    y_low     <= s.yl;
    y_high    <= s.yh;
    z_low     <= s.zl;
    z_high    <= s.zh;
    last_slot <= s.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rate(s, produced, r);
    if (produced)
      rates_due.push_back(typed ? want : r);
    accepted++;
  endtask

  // hold off input until every result is out and the divider has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [SCALE_W-1:0] scale, input logic mode,
                               input bit every);
    bit write_scale, write_mode;
    write_scale = every || scale != model_scale;
    write_mode  = every || mode != model_mode;
    if (write_scale || write_mode) begin
      wait_drained();
      if (write_scale) begin
        cfg_write <= 1'b1;
        cfg_index <= REG_SCALE_SELECT;
        cfg_data  <= scale;
        @(posedge clk);
        model_scale = scale;
      end
      if (write_mode) begin
        // upper data bit is don't-care for the mode register
        cfg_write <= 1'b1;
        cfg_index <= REG_AVERAGING_MODE;
        cfg_data  <= {every ? 1'($urandom_range(1)) : 1'b0, mode};
        @(posedge clk);
        model_mode = mode;
      end
      cfg_write <= 1'b0;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_rates
    rate_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rates_due.size() == 0) begin
        flag_mismatch("result with none due, rate_x", longint'(rate_x), longint'(0));
      end else begin
        want = rates_due.pop_front();
        if (rate_x !== want.rx)
          flag_mismatch("rate_x", longint'(rate_x), longint'(want.rx));
        if (rate_y !== want.ry)
          flag_mismatch("rate_y", longint'(rate_y), longint'(want.ry));
        if (rate_z !== want.rz)
          flag_mismatch("rate_z", longint'(rate_z), longint'(want.rz));
        if (slots_averaged !== want.cnt)
          flag_mismatch("slots_averaged", longint'(slots_averaged), longint'(want.cnt));
        if (forced_end !== want.forced)
          flag_mismatch("forced_end", longint'(forced_end), longint'(want.forced));
      end
    end
  end

  initial begin : stimulus
    gyro_slot_t s;
    int burst, phase_end, pick;
    logic [SCALE_W-1:0] scale_pick;
    logic mode_pick;

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    x_low     <= '0;
    x_high    <= '0;
    y_low     <= '0;
    y_high    <= '0;
    z_low     <= '0;
    z_high    <= '0;
    last_slot <= 1'b0;
    model_scale = SCALE_NONE;
    model_mode  = MODE_BYPASS;
    no_rate     = '{default: '0};
    sum_x   = 0;
    sum_y   = 0;
    sum_z   = 0;
    run_len = 0;

    // directed table: scale, mode, repeats, x, y, z, last, typed result
    // reset state: invalid scale gives zero rates
    add_row(SCALE_NONE, MODE_BYPASS, 1, 16'h7FFF, 16'h8000, 16'h1234, 1'b0,
            1, 0, 0, 0, 1, 0);
    // bypass extremes, last mark ignored
    add_row(SCALE_2000DPS, MODE_BYPASS, 1, 16'h8000, 16'h7FFF, 16'h0000, 1'b1,
            1, -64'sd2293760000, 64'sd2293690000, 0, 1, 0);
    // low byte taken unsigned
    add_row(SCALE_245DPS, MODE_BYPASS, 1, 16'hFFFF, 16'h0001, 16'h00FF, 1'b0,
            1, -8750, 8750, 2231250, 1, 0);
    add_row(SCALE_500DPS, MODE_BYPASS, 1, 16'h80FF, 16'h7F00, 16'hFF80, 1'b0);
    // single-slot run: most negative sample keeps its sign
    add_row(SCALE_2000DPS, MODE_STREAM, 1, 16'h8000, 16'h7FFF, 16'h8001, 1'b1,
            1, -64'sd2293760000, -64'sd2293690000, 64'sd2293690000, 1, 0);
    // two-slot run: quotient truncates toward zero
    add_row(SCALE_245DPS, MODE_STREAM, 1, 16'h0001, 16'hFFFF, 16'h0003, 1'b0);
    add_row(SCALE_245DPS, MODE_STREAM, 1, 16'h0000, 16'h0000, 16'h0000, 1'b1,
            1, 0, 0, -8750, 2, 0);
    add_row(SCALE_500DPS, MODE_STREAM, 1, 16'h1234, 16'hEDCB, 16'h00FF, 1'b0);
    add_row(SCALE_500DPS, MODE_STREAM, 1, 16'h7FFF, 16'h8000, 16'hFF00, 1'b0);
    add_row(SCALE_500DPS, MODE_STREAM, 1, 16'h0101, 16'hFEFE, 16'h55AA, 1'b1);
    // mode change mid-run: bypass slot leaves the run alone
    add_row(SCALE_500DPS, MODE_STREAM, 1, 16'h4000, 16'hC000, 16'h0007, 1'b0);
    add_row(SCALE_500DPS, MODE_BYPASS, 1, 16'hAAAA, 16'h5555, 16'h0F0F, 1'b1);
    add_row(SCALE_2000DPS, MODE_STREAM, 1, 16'h2000, 16'hE000, 16'h0003, 1'b1);
    // full run without last mark is forced to end
    add_row(SCALE_2000DPS, MODE_STREAM, RUN_SLOTS, 16'h8000, 16'h8000, 16'h8000, 1'b0,
            1, -64'sd2293760000, -64'sd2293760000, -64'sd2293760000, 32, 1);
    // full run closed by a last mark on the final slot
    add_row(SCALE_245DPS, MODE_STREAM, RUN_SLOTS - 1, 16'h7FFF, 16'h0000, 16'h0001, 1'b0);
    add_row(SCALE_245DPS, MODE_STREAM, 1, 16'h7FFF, 16'h0000, 16'h0001, 1'b1);
    add_row(SCALE_NONE, MODE_STREAM, 1, 16'h8000, 16'h7FFF, 16'h1234, 1'b1,
            1, 0, 0, 0, 1, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table walk
    foreach (directed_plan[i]) begin
      apply_setting(directed_plan[i].scale, directed_plan[i].mode, 1'b0);
      repeat (directed_plan[i].reps)
        send_slot(directed_plan[i].slot, directed_plan[i].typed, directed_plan[i].want);
    end

    // random phases, each under a fresh register setting
    accepted = 0;
    while (accepted < RANDOM_SLOTS) begin
      idle_mode  = accepted * 3 / RANDOM_SLOTS;
      scale_pick = SCALE_W'($urandom_range(3));
      mode_pick  = ($urandom_range(3) != 0) ? MODE_STREAM : MODE_BYPASS;
      apply_setting(scale_pick, mode_pick, 1'b1);
      phase_end = accepted + $urandom_range(40, 120);
      while (accepted < phase_end) begin
        if (model_mode == MODE_STREAM) begin
          // mostly short bursts, some long, some past capacity
          pick  = $urandom_range(9);
          burst = (pick < 6) ? $urandom_range(1, 8) :
                  (pick < 9) ? $urandom_range(9, RUN_SLOTS - 1) :
                               $urandom_range(RUN_SLOTS, RUN_SLOTS + 8);
          for (int k = 1; k <= burst; k++) begin
            s = random_slot();
            s.last = (k == burst) && (burst <= RUN_SLOTS);
            if ($urandom_range(19) == 0)
              s.last = !s.last;
            send_slot(s, 1'b0, no_rate);
          end
        end else begin
          send_slot(random_slot(), 1'b0, no_rate);
        end
        if ($urandom_range(149) == 0)
          wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0)
      $display("gyro_fifo_average_scale_test: clean");
    else
      $display("gyro_fifo_average_scale_test: errors");
    $finish;
  end

endmodule
